/* hdl/fmdbb_pkg.sv */
// Shared constants and helpers for the FIX market data best bid extractor.
`timescale 1ns / 1ps

package fmdbb_pkg;

   // Default build settings.
   localparam int unsigned DEF_VALUE_CHARS    = 8;
   localparam int unsigned DEF_PRICE_DECIMALS = 4;
   localparam int unsigned DEF_SECURITY_CHARS = 7;

   // Field widths.
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned TAG_W   = 17;
   localparam int unsigned COUNT_W = 4;
   localparam int unsigned FRAC_W  = 3;
   localparam int unsigned PRICE_W = 40;
   localparam int unsigned POW_W   = 20;

   // Character codes.
   localparam logic [BYTE_W-1:0] SOH_CHAR      = 8'h01;
   localparam logic [BYTE_W-1:0] EQ_CHAR       = 8'h3D;
   localparam logic [BYTE_W-1:0] DOT_CHAR      = 8'h2E;
   localparam logic [BYTE_W-1:0] SPACE_CHAR    = 8'h20;
   localparam logic [BYTE_W-1:0] ZERO_CHAR     = 8'h30;
   localparam logic [BYTE_W-1:0] NINE_CHAR     = 8'h39;
   localparam logic [BYTE_W-1:0] BID_KIND      = 8'h30;
   localparam logic [BYTE_W-1:0] CLOSE_KIND    = 8'h35;
   localparam logic [BYTE_W-1:0] SNAPSHOT_KIND = 8'h57;

   // Tag numbers of interest.
   localparam logic [TAG_W-1:0] TAG_MSG_TYPE   = 17'd35;
   localparam logic [TAG_W-1:0] TAG_SECURITY   = 17'd48;
   localparam logic [TAG_W-1:0] TAG_ENTRY_TYPE = 17'd269;
   localparam logic [TAG_W-1:0] TAG_ENTRY_PX   = 17'd270;
   localparam logic [TAG_W-1:0] TAG_ENTRY_SIZE = 17'd271;
   localparam logic [TAG_W-1:0] TAG_MAX        = 17'h1FFFF;

   // Bit positions in the tags-seen mask.
   localparam int unsigned SEEN_SECURITY   = 0;
   localparam int unsigned SEEN_ENTRY_TYPE = 1;
   localparam int unsigned SEEN_ENTRY_PX   = 2;
   localparam int unsigned SEEN_ENTRY_SIZE = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;
   localparam logic [PRICE_W-1:0] PRICE_MAX = 40'hFF_FFFF_FFFF;

   // Powers of ten used to place a digit at its fixed point weight.
   function automatic logic [POW_W-1:0] pow10(input logic [FRAC_W-1:0] e);
      logic [POW_W-1:0] r;
      case (e)
         3'd0:    r = 20'd1;
         3'd1:    r = 20'd10;
         3'd2:    r = 20'd100;
         3'd3:    r = 20'd1000;
         3'd4:    r = 20'd10000;
         3'd5:    r = 20'd100000;
         3'd6:    r = 20'd1000000;
         default: r = 20'd0;
      endcase
      return r;
   endfunction

endpackage

/* hdl/fmdbb_if.sv */
// Handshake interfaces for the message byte channel and the result channel.
`timescale 1ns / 1ps

interface fmdbb_req_if;
   import fmdbb_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] byte_in;
   logic              message_end;
   modport source (output valid, byte_in, message_end, input ready);
   modport sink   (input valid, byte_in, message_end, output ready);
endinterface

interface fmdbb_rsp_if;
   import fmdbb_pkg::*;
   logic               valid;
   logic               ready;
   logic               security_match;
   logic               snapshot_type;
   logic               required_tags_seen;
   logic               bid_found;
   logic [PRICE_W-1:0] best_bid;
   logic               close_found;
   logic [PRICE_W-1:0] closing_price;
   modport source (output valid, security_match, snapshot_type, required_tags_seen,
                   bid_found, best_bid, close_found, closing_price, input ready);
   modport sink   (input valid, security_match, snapshot_type, required_tags_seen,
                   bid_found, best_bid, close_found, closing_price, output ready);
endinterface

/* hdl/fix_market_data_best_bid.sv */
// Top level of the FIX market data best bid extractor.
`timescale 1ns / 1ps

// Channel  | Direction | Beat contents
// ---------+-----------+-------------------------------------------------------
// req_ch   | in        | byte_in, message_end: one message byte a beat
// rsp_ch   | out       | one result beat per message: match flags and prices
// csr_*    | in        | csr_we / csr_wdata: watched security id, no read-back
//
// Each byte beat is held in the input register and parsed from there; a message-ending
// byte also loads the result register, from which its result beat is offered.
// A byte beat can be accepted in every cycle unless a stalled result beat holds one back.
// Reset is synchronous and active high; it clears the parse state, the watched
// security id and both valid flags.
// A stalled result beat holds only the next message-ending byte, and the input behind it.

module fix_market_data_best_bid #(
   parameter int unsigned VALUE_CHARS    = fmdbb_pkg::DEF_VALUE_CHARS,
   parameter int unsigned PRICE_DECIMALS = fmdbb_pkg::DEF_PRICE_DECIMALS,
   parameter int unsigned SECURITY_CHARS = fmdbb_pkg::DEF_SECURITY_CHARS
) (
   input  logic                        clock,
   input  logic                        reset,
   fmdbb_req_if.sink                   req_ch,
   fmdbb_rsp_if.source                 rsp_ch,
   input  logic                        csr_we,
   input  logic [8*SECURITY_CHARS-1:0] csr_wdata
);
   import fmdbb_pkg::*;

   localparam int unsigned ID_W  = 8 * SECURITY_CHARS;
   localparam int unsigned MAC_W = PRICE_W + 5;
   localparam int unsigned DT_W  = POW_W + 4;

   // Input register.
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_end_ff;

   // Configuration.
   logic [ID_W-1:0] watched_ff;

   // Parse state.
   logic               in_value_ff, in_value_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ID_W-1:0]    id_shift_ff, id_shift_in;
   logic [BYTE_W-1:0]  first_char_ff, first_char_in;
   logic [PRICE_W-1:0] scaled_ff, scaled_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic               point_ff, point_in;
   logic [BYTE_W-1:0]  entry_kind_ff, entry_kind_in;
   logic [BYTE_W-1:0]  msg_kind_ff, msg_kind_in;
   logic [ID_W-1:0]    cur_sec_ff, cur_sec_in;
   logic [3:0]         seen_ff, seen_in;
   logic [PRICE_W-1:0] bid_ff, bid_in;
   logic [PRICE_W-1:0] close_ff, close_in;
   logic               close_seen_ff, close_seen_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               sec_match_ff, sec_match_in;
   logic               snapshot_ff, snapshot_in;
   logic               required_ff, required_in;
   logic               bid_found_ff, bid_found_in;
   logic [PRICE_W-1:0] best_bid_ff, best_bid_in;
   logic               close_found_ff, close_found_in;
   logic [PRICE_W-1:0] closing_ff, closing_in;

   logic req_fire;
   logic advance;

   // A message-ending byte may only move on when the result slot is free or
   // being emptied in the same cycle.
   assign advance  = in_valid_ff &&
                     !(in_end_ff && rsp_valid_ff && !rsp_ch.ready);
   assign req_fire = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !in_valid_ff || advance;
   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = (advance && in_end_ff) ? 1'b1 :
                         (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   // Per-byte parse pass: tag accumulation, value handling, field close and,
   // on the last byte of a message, the result and the clearing of all state.
   always_comb begin
      logic                  is_digit;
      logic [3:0]            digit;
      logic [TAG_W+3:0]      tag_wide;
      logic [ID_W+7:0]       id_cat;
      logic [MAC_W-1:0]      mac;
      logic [DT_W-1:0]       digit_term;
      logic [FRAC_W-1:0]     frac_exp;
      logic                  close_now;

      in_value_in   = in_value_ff;
      tag_in        = tag_ff;
      count_in      = count_ff;
      id_shift_in   = id_shift_ff;
      first_char_in = first_char_ff;
      scaled_in     = scaled_ff;
      frac_in       = frac_ff;
      point_in      = point_ff;
      entry_kind_in = entry_kind_ff;
      msg_kind_in   = msg_kind_ff;
      cur_sec_in    = cur_sec_ff;
      seen_in       = seen_ff;
      bid_in        = bid_ff;
      close_in      = close_ff;
      close_seen_in = close_seen_ff;

      is_digit   = (in_byte_ff >= ZERO_CHAR) && (in_byte_ff <= NINE_CHAR);
      digit      = in_byte_ff[3:0];
      tag_wide   = (TAG_W+4)'(tag_ff) * (TAG_W+4)'(10) + (TAG_W+4)'(digit);
      id_cat     = {id_shift_ff, in_byte_ff};
      mac        = '0;
      digit_term = '0;
      frac_exp   = FRAC_W'(PRICE_DECIMALS - 1) - frac_ff;

      if (!in_value_ff) begin
         if (in_byte_ff == SOH_CHAR) begin
            tag_in = '0;
         end else if (in_byte_ff == EQ_CHAR) begin
            in_value_in   = 1'b1;
            count_in      = '0;
            id_shift_in   = '0;
            first_char_in = SPACE_CHAR;
            scaled_in     = '0;
            frac_in       = '0;
            point_in      = 1'b0;
         end else if (is_digit && tag_ff != TAG_MAX) begin
            tag_in = (tag_wide > (TAG_W+4)'(TAG_MAX)) ? TAG_MAX : tag_wide[TAG_W-1:0];
         end else begin
            tag_in = TAG_MAX;
         end
      end else if (in_byte_ff != SOH_CHAR) begin
         if (count_ff == '0) begin
            first_char_in = in_byte_ff;
         end
         if (count_ff < COUNT_W'(SECURITY_CHARS)) begin
            id_shift_in = id_cat[ID_W-1:0];
         end
         if (tag_ff == TAG_ENTRY_PX && count_ff < COUNT_W'(VALUE_CHARS)) begin
            if (is_digit) begin
               // The accumulator always holds the price already scaled to
               // full precision, saturated at the 40-bit ceiling.
               if (!point_ff) begin
                  digit_term = DT_W'(digit) * DT_W'(pow10(FRAC_W'(PRICE_DECIMALS)));
                  mac        = MAC_W'(scaled_ff) * MAC_W'(10) + MAC_W'(digit_term);
                  scaled_in  = (mac > MAC_W'(PRICE_MAX)) ? PRICE_MAX : mac[PRICE_W-1:0];
               end else if (frac_ff < FRAC_W'(PRICE_DECIMALS)) begin
                  digit_term = DT_W'(digit) * DT_W'(pow10(frac_exp));
                  mac        = MAC_W'(scaled_ff) + MAC_W'(digit_term);
                  scaled_in  = (mac > MAC_W'(PRICE_MAX)) ? PRICE_MAX : mac[PRICE_W-1:0];
                  frac_in    = frac_ff + FRAC_W'(1);
               end
            end else if (in_byte_ff == DOT_CHAR && !point_ff) begin
               point_in = 1'b1;
            end else begin
               count_in = COUNT_MAX;
            end
         end
         if (count_in != COUNT_MAX) begin
            count_in = count_in + COUNT_W'(1);
         end
      end

      // A field closes on SOH inside a value, or when the message ends in one.
      close_now = in_value_in &&
                  ((in_value_ff && in_byte_ff == SOH_CHAR) || in_end_ff);

      if (close_now) begin
         unique case (tag_in)
            TAG_MSG_TYPE: begin
               msg_kind_in = first_char_in;
            end
            TAG_SECURITY: begin
               cur_sec_in             = id_shift_in;
               seen_in[SEEN_SECURITY] = 1'b1;
            end
            TAG_ENTRY_TYPE: begin
               entry_kind_in            = first_char_in;
               seen_in[SEEN_ENTRY_TYPE] = 1'b1;
            end
            TAG_ENTRY_PX: begin
               seen_in[SEEN_ENTRY_PX] = 1'b1;
               if (entry_kind_in == BID_KIND) begin
                  if (scaled_in > bid_ff) begin
                     bid_in = scaled_in;
                  end
               end else if (entry_kind_in == CLOSE_KIND) begin
                  close_in      = scaled_in;
                  close_seen_in = 1'b1;
               end
            end
            TAG_ENTRY_SIZE: begin
               seen_in[SEEN_ENTRY_SIZE] = 1'b1;
            end
            default: begin
            end
         endcase
         in_value_in = 1'b0;
         tag_in      = '0;
      end

      sec_match_in   = seen_in[SEEN_SECURITY] && (cur_sec_in == watched_ff);
      snapshot_in    = (msg_kind_in == SNAPSHOT_KIND);
      required_in    = (seen_in == 4'hF);
      bid_found_in   = (bid_in != '0);
      best_bid_in    = bid_in;
      close_found_in = close_seen_in;
      closing_in     = close_in;

      if (in_end_ff) begin
         in_value_in   = 1'b0;
         tag_in        = '0;
         count_in      = '0;
         id_shift_in   = '0;
         first_char_in = SPACE_CHAR;
         scaled_in     = '0;
         frac_in       = '0;
         point_in      = 1'b0;
         entry_kind_in = SPACE_CHAR;
         msg_kind_in   = SPACE_CHAR;
         cur_sec_in    = '0;
         seen_in       = '0;
         bid_in        = '0;
         close_in      = '0;
         close_seen_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         watched_ff    <= '0;
         in_value_ff   <= 1'b0;
         tag_ff        <= '0;
         count_ff      <= '0;
         id_shift_ff   <= '0;
         first_char_ff <= SPACE_CHAR;
         scaled_ff     <= '0;
         frac_ff       <= '0;
         point_ff      <= 1'b0;
         entry_kind_ff <= SPACE_CHAR;
         msg_kind_ff   <= SPACE_CHAR;
         cur_sec_ff    <= '0;
         seen_ff       <= '0;
         bid_ff        <= '0;
         close_ff      <= '0;
         close_seen_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            watched_ff <= csr_wdata;
         end
         if (advance) begin
            in_value_ff   <= in_value_in;
            tag_ff        <= tag_in;
            count_ff      <= count_in;
            id_shift_ff   <= id_shift_in;
            first_char_ff <= first_char_in;
            scaled_ff     <= scaled_in;
            frac_ff       <= frac_in;
            point_ff      <= point_in;
            entry_kind_ff <= entry_kind_in;
            msg_kind_ff   <= msg_kind_in;
            cur_sec_ff    <= cur_sec_in;
            seen_ff       <= seen_in;
            bid_ff        <= bid_in;
            close_ff      <= close_in;
            close_seen_ff <= close_seen_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_ch.byte_in;
         in_end_ff  <= req_ch.message_end;
      end
      if (advance && in_end_ff) begin
         sec_match_ff   <= sec_match_in;
         snapshot_ff    <= snapshot_in;
         required_ff    <= required_in;
         bid_found_ff   <= bid_found_in;
         best_bid_ff    <= best_bid_in;
         close_found_ff <= close_found_in;
         closing_ff     <= closing_in;
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.security_match     = sec_match_ff;
   assign rsp_ch.snapshot_type      = snapshot_ff;
   assign rsp_ch.required_tags_seen = required_ff;
   assign rsp_ch.bid_found          = bid_found_ff;
   assign rsp_ch.best_bid           = best_bid_ff;
   assign rsp_ch.close_found        = close_found_ff;
   assign rsp_ch.closing_price      = closing_ff;

endmodule
